FILE: src/rrtq_pkg.sv
// Package for the round-robin task queue: item types, entry layout, codes, the
// controller state, command and status types. Used by every module of the block.
package rrtq_pkg;

  typedef struct packed {
    logic [1:0] action;
    logic [4:0] target_id;
    logic [2:0] new_state;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] task_number;
    logic [2:0] old_state;
    logic [2:0] next_state;
    logic       removed;
    logic [4:0] tasks_queued;
  } out_item_t;

  // One queue slot as it is held in the entry memory.
  typedef struct packed {
    logic [4:0] id;
    logic [2:0] st;
  } entry_t;

  // Action codes.
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_CREATE = 2'd1;
  localparam logic [1:0] ACT_SET    = 2'd2;

  // Task state codes.
  localparam logic [2:0] TS_DEAD    = 3'd0;
  localparam logic [2:0] TS_IDLE    = 3'd1;
  localparam logic [2:0] TS_BLOCKED = 3'd2;
  localparam logic [2:0] TS_READY   = 3'd3;
  localparam logic [2:0] TS_RUNNING = 3'd4;

  // Result status codes.
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_EMPTY     = 3'd1;
  localparam logic [2:0] STAT_FULL      = 3'd2;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [2:0] STAT_UNCHANGED = 3'd4;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_DECODE,
    CS_TICK,
    CS_SCAN,
    CS_EMIT
  } rrtq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic decode;
    logic tick_eval;
    logic scan;
    logic emit;
  } rrtq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] action;
    logic       empty;
    logic       scan_end;
    logic       out_free;
  } rrtq_stat_t;

endpackage

FILE: src/rrtq_ctrl.sv
// Controller state machine of the round-robin task queue.
// Depends on rrtq_pkg for the state, command and status types.
module rrtq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rrtq_pkg::rrtq_stat_t stat,
  output rrtq_pkg::rrtq_cmd_t  cmd
);

  rrtq_pkg::rrtq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrtq_pkg::CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rrtq_pkg::CS_IDLE: begin
        if (in_valid) state_nxt = rrtq_pkg::CS_DECODE;
      end
      rrtq_pkg::CS_DECODE: begin
        if (!stat.empty && stat.action == rrtq_pkg::ACT_TICK) begin
          state_nxt = rrtq_pkg::CS_TICK;
        end else if (!stat.empty && stat.action == rrtq_pkg::ACT_SET) begin
          state_nxt = rrtq_pkg::CS_SCAN;
        end else begin
          state_nxt = rrtq_pkg::CS_EMIT;
        end
      end
      rrtq_pkg::CS_TICK: begin
        state_nxt = rrtq_pkg::CS_EMIT;
      end
      rrtq_pkg::CS_SCAN: begin
        if (stat.scan_end) state_nxt = rrtq_pkg::CS_EMIT;
      end
      rrtq_pkg::CS_EMIT: begin
        if (stat.out_free) state_nxt = rrtq_pkg::CS_IDLE;
      end
      default: begin
        state_nxt = rrtq_pkg::CS_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      rrtq_pkg::CS_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      rrtq_pkg::CS_DECODE: begin
        cmd.decode = 1'b1;
      end
      rrtq_pkg::CS_TICK: begin
        cmd.tick_eval = 1'b1;
      end
      rrtq_pkg::CS_SCAN: begin
        cmd.scan = 1'b1;
      end
      rrtq_pkg::CS_EMIT: begin
        cmd.emit = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: src/rrtq_datapath.sv
// Datapath of the round-robin task queue: entry memory, ring pointers,
// counters, search pointer, result staging and output register.
// Depends on rrtq_pkg for item, entry, code and command types.
module rrtq_datapath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rrtq_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rrtq_pkg::out_item_t  out_data,
  input  rrtq_pkg::rrtq_cmd_t  cmd,
  output rrtq_pkg::rrtq_stat_t stat
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

  rrtq_pkg::entry_t    mem [QUEUE_DEPTH];
  rrtq_pkg::entry_t    rd_data_r;
  logic [PTR_W-1:0]    rd_addr, rd_addr_r;
  logic                wr_en;
  logic [PTR_W-1:0]    wr_addr;
  rrtq_pkg::entry_t    wr_data;

  rrtq_pkg::in_item_t  item_r;
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [PTR_W-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [4:0]          worker_r, worker_nxt;
  logic [PTR_W-1:0]    scan_r, scan_nxt;
  logic [CNT_W-1:0]    seen_r, seen_nxt;
  rrtq_pkg::out_item_t res_r, res_nxt;
  rrtq_pkg::out_item_t emit_data;
  rrtq_pkg::out_item_t out_r;
  logic                out_valid_r, out_valid_nxt;

  logic                match;
  logic                scan_last;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  assign match     = (rd_data_r.id == item_r.target_id);
  assign scan_last = (seen_r == count_r);

  assign stat.action   = item_r.action;
  assign stat.empty    = (count_r == '0);
  assign stat.scan_end = match || scan_last;
  assign stat.out_free = !out_valid_r || out_ready;

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    rd_addr_r <= rd_addr;
  end

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    worker_nxt    = worker_r;
    scan_nxt      = scan_r;
    seen_nxt      = seen_r;
    res_nxt       = res_r;
    rd_addr       = scan_r;
    wr_en         = 1'b0;
    wr_addr       = tail_r;
    wr_data       = rd_data_r;
    out_valid_nxt = out_valid_r;

    if (cmd.decode) begin
      res_nxt = '0;
      rd_addr = head_r;
      case (item_r.action)
        rrtq_pkg::ACT_TICK: begin
          if (count_r == '0) res_nxt.status = rrtq_pkg::STAT_EMPTY;
        end
        rrtq_pkg::ACT_CREATE: begin
          if (count_r == FULL_CNT) begin
            res_nxt.status = rrtq_pkg::STAT_FULL;
          end else begin
            worker_nxt         = worker_r + 5'd1;
            wr_en              = 1'b1;
            wr_data.id         = worker_nxt;
            wr_data.st         = (count_r == '0) ? rrtq_pkg::TS_RUNNING
                                                 : rrtq_pkg::TS_READY;
            tail_nxt           = ring_next(tail_r);
            count_nxt          = count_r + 1'b1;
            res_nxt.task_number = worker_nxt;
            res_nxt.next_state  = wr_data.st;
          end
        end
        rrtq_pkg::ACT_SET: begin
          if (count_r == '0) begin
            res_nxt.status = rrtq_pkg::STAT_EMPTY;
          end else begin
            scan_nxt = ring_next(head_r);
            seen_nxt = CNT_W'(1);
          end
        end
        default: begin
          res_nxt = '0;
        end
      endcase
    end

    if (cmd.tick_eval) begin
      res_nxt.status      = rrtq_pkg::STAT_OK;
      res_nxt.task_number = rd_data_r.id;
      res_nxt.old_state   = rd_data_r.st;
      head_nxt            = ring_next(head_r);
      if (rd_data_r.st == rrtq_pkg::TS_DEAD) begin
        count_nxt          = count_r - 1'b1;
        worker_nxt         = (worker_r != '0) ? worker_r - 5'd1 : worker_r;
        res_nxt.next_state = rd_data_r.st;
        res_nxt.removed    = 1'b1;
      end else begin
        wr_en              = 1'b1;
        wr_data.id         = rd_data_r.id;
        wr_data.st         = (rd_data_r.st == rrtq_pkg::TS_READY) ?
                             rrtq_pkg::TS_RUNNING : rrtq_pkg::TS_READY;
        tail_nxt           = ring_next(tail_r);
        res_nxt.next_state = wr_data.st;
      end
    end

    if (cmd.scan) begin
      res_nxt.task_number = item_r.target_id;
      if (match) begin
        res_nxt.old_state = rd_data_r.st;
        if (rd_data_r.st == item_r.new_state ||
            !(item_r.new_state inside {[rrtq_pkg::TS_DEAD:rrtq_pkg::TS_RUNNING]})) begin
          res_nxt.status     = rrtq_pkg::STAT_UNCHANGED;
          res_nxt.next_state = rd_data_r.st;
        end else begin
          res_nxt.status     = rrtq_pkg::STAT_OK;
          res_nxt.next_state = item_r.new_state;
          wr_en              = 1'b1;
          wr_addr            = rd_addr_r;
          wr_data.id         = rd_data_r.id;
          wr_data.st         = item_r.new_state;
        end
      end else if (scan_last) begin
        res_nxt.status = rrtq_pkg::STAT_NOT_FOUND;
      end else begin
        scan_nxt = ring_next(scan_r);
        seen_nxt = seen_r + 1'b1;
      end
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // The staged result with the current entry count filled in.
  always_comb begin
    emit_data              = res_r;
    emit_data.tasks_queued = 5'(count_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      worker_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      worker_r    <= worker_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) item_r <= in_data;
    scan_r <= scan_nxt;
    seen_r <= seen_nxt;
    res_r  <= res_nxt;
    if (cmd.emit) out_r <= emit_data;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: src/round_robin_task_queue.sv
// Top level of the round-robin task queue: joins controller and datapath.
// Depends on rrtq_pkg, rrtq_ctrl and rrtq_datapath.
//
// The block holds a ring of up to QUEUE_DEPTH tasks, each an id and a state,
// and works on one action at a time. A tick goes from decode through a tick
// update to the load of the output register; create, actions on an empty
// ring and the unused action code go from decode straight to the load. A set
// searches the ring from the front one entry per cycle through the single
// read port of the entry memory, until it finds the id or has looked at every
// queued entry, and then loads the output register. After the load the block
// returns to idle before it takes the next action.
// The result sits in an output register; the next action is taken while it
// waits, and the block holds that next result back until the first one is
// transferred. The entry memory has no reset and needs no clearing pass.
module round_robin_task_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rrtq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rrtq_pkg::out_item_t out_data
);

  // Command and status groups between the controller and the datapath.
  rrtq_pkg::rrtq_cmd_t  cmd;
  rrtq_pkg::rrtq_stat_t stat;

  // The controller sequences each action: decode, then a tick update or a search
  // where the action needs one, then the load of the output register.
  rrtq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath owns the entry memory, the ring pointers and counters,
  // and the output register.
  rrtq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

FILE: sim/rrtq_checker.sv
// Checker for the round-robin task queue: watches both channels, predicts every result
// and compares it with what the block delivers. Depends on rrtq_pkg.
`timescale 1ns / 1ps

module rrtq_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  rrtq_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  rrtq_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending
);

  // Shadow copy of the ring and its counters.
  logic [4:0] ring_ids [QUEUE_DEPTH];
  logic [2:0] ring_sts [QUEUE_DEPTH];
  int         ring_head;
  int         ring_tail;
  int         ring_count;
  logic [4:0] workers;

  rrtq_pkg::out_item_t expected_results[$];
  int                  errors;

  function automatic int ring_next(int p);
    return (p + 1 >= QUEUE_DEPTH) ? 0 : p + 1;
  endfunction

  function automatic rrtq_pkg::out_item_t predict_action(rrtq_pkg::in_item_t item);
    rrtq_pkg::out_item_t r;
    logic [4:0] id;
    logic [2:0] olds;
    int         p;
    bit         found;
    r = '0;
    case (item.action)
      rrtq_pkg::ACT_TICK: begin
        if (ring_count == 0) begin
          r.status = rrtq_pkg::STAT_EMPTY;
        end else begin
          id   = ring_ids[ring_head];
          olds = ring_sts[ring_head];
          ring_head = ring_next(ring_head);
          r.task_number = id;
          r.old_state   = olds;
          if (olds == rrtq_pkg::TS_DEAD) begin
            ring_count--;
            if (workers != 5'd0) workers = workers - 5'd1;
            r.next_state = olds;
            r.removed    = 1'b1;
          end else begin
            r.next_state = (olds == rrtq_pkg::TS_READY) ? rrtq_pkg::TS_RUNNING
                                                        : rrtq_pkg::TS_READY;
            ring_ids[ring_tail] = id;
            ring_sts[ring_tail] = r.next_state;
            ring_tail = ring_next(ring_tail);
          end
        end
      end
      rrtq_pkg::ACT_CREATE: begin
        if (ring_count >= QUEUE_DEPTH) begin
          r.status = rrtq_pkg::STAT_FULL;
        end else begin
          workers = workers + 5'd1;
          r.task_number = workers;
          r.next_state  = (ring_count == 0) ? rrtq_pkg::TS_RUNNING
                                            : rrtq_pkg::TS_READY;
          ring_ids[ring_tail] = workers;
          ring_sts[ring_tail] = r.next_state;
          ring_tail = ring_next(ring_tail);
          ring_count++;
        end
      end
      rrtq_pkg::ACT_SET: begin
        if (ring_count == 0) begin
          r.status = rrtq_pkg::STAT_EMPTY;
        end else begin
          p = ring_head;
          found = 1'b0;
          for (int k = 0; k < ring_count && !found; k++) begin
            if (ring_ids[p] == item.target_id) found = 1'b1;
            else p = ring_next(p);
          end
          r.task_number = item.target_id;
          if (!found) begin
            r.status = rrtq_pkg::STAT_NOT_FOUND;
          end else begin
            olds = ring_sts[p];
            r.old_state = olds;
            if (olds == item.new_state || item.new_state > rrtq_pkg::TS_RUNNING) begin
              r.status     = rrtq_pkg::STAT_UNCHANGED;
              r.next_state = olds;
            end else begin
              ring_sts[p]  = item.new_state;
              r.next_state = item.new_state;
            end
          end
        end
      end
      default: ;
    endcase
    r.tasks_queued = 5'(ring_count);
    return r;
  endfunction

  task automatic compare_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    rrtq_pkg::out_item_t want;
    if (!rst_n) begin
      ring_head  = 0;
      ring_tail  = 0;
      ring_count = 0;
      workers    = '0;
      errors     = 0;
      expected_results.delete();
    end else begin
      // The result of an earlier action is checked before this edge's new action is
      // predicted.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no action outstanding");
          errors++;
        end else begin
          want = expected_results.pop_front();
          compare_field("status", want.status, out_data.status);
          compare_field("task_number", want.task_number, out_data.task_number);
          compare_field("old_state", want.old_state, out_data.old_state);
          compare_field("next_state", want.next_state, out_data.next_state);
          compare_field("removed", want.removed, out_data.removed);
          compare_field("tasks_queued", want.tasks_queued, out_data.tasks_queued);
        end
      end
      if (in_valid && in_ready) expected_results.push_back(predict_action(in_data));
    end
    fail_count <= errors;
    pending    <= expected_results.size();
  end

endmodule

FILE: sim/tb_top.sv
// Top of the round-robin task queue testbench: clock, reset, stimulus, the receive side
// and the verdict. Depends on rrtq_pkg, round_robin_task_queue and rrtq_checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int         QUEUE_DEPTH  = 16;
  localparam int         RANDOM_ITEMS = 1950;
  localparam int         MAX_GAP      = 18;
  // The block treats the fourth action code as a no-op.
  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  // No correct run goes this long without a transfer: a receiver stall, a sender gap
  // and the longest search add up to far less than STALL_LIMIT.
  localparam int         STALL_LIMIT  = 2000;
  // Cycles to watch for stray results once nothing is outstanding.
  localparam int         DRAIN_CYCLES = 40;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  rrtq_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  rrtq_pkg::out_item_t out_data;
  int                  fail_count;
  int                  pending;

  // The sender and the receiver each draw a wait from 0 to MAX_GAP per transfer.
  // Each side also has back-to-back stretches.
  bit        send_burst = 1'b0;
  int        idle_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  round_robin_task_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  rrtq_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Watchdog: the run is stuck if neither channel completes a transfer before
  // the idle count reaches STALL_LIMIT.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one action. The task is entered just after the edge that took the previous
  // transfer. A gap of zero keeps valid high, so the next action follows back to back.
  task automatic send_item(input rrtq_pkg::in_item_t item);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the sender off until every outstanding result has been delivered.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Receive side. Ready is raised after a random wait and stays up until a result
  // transfer happens. A zero wait leaves it up, so ready is never lowered and raised
  // within one time step.
  initial begin
    int  wait_cycles;
    int  results_seen;
    bit  recv_burst;
    results_seen = 0;
    recv_burst   = 1'b0;
    @(posedge rst_n);
    forever begin
      if (results_seen % 100 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      wait_cycles = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clk);
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_seen++;
    end
  end

  initial begin
    rrtq_pkg::in_item_t item;
    int                 mode;
    int                 pick;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. The ring is empty at first. Then it is filled to the limit. Then
    // each outcome of set is hit, and a dead task is removed from the front.
    send_item(rrtq_pkg::in_item_t'{rrtq_pkg::ACT_TICK, 5'd0, rrtq_pkg::TS_DEAD});
    send_item(rrtq_pkg::in_item_t'{rrtq_pkg::ACT_SET, 5'd0, rrtq_pkg::TS_DEAD});
    send_item(rrtq_pkg::in_item_t'{ACT_UNUSED, 5'd31, 3'd7});
    repeat (QUEUE_DEPTH)
      send_item(rrtq_pkg::in_item_t'{rrtq_pkg::ACT_CREATE, 5'd0, rrtq_pkg::TS_DEAD});
    // A create is refused on a full ring. A tick on a full ring moves the front entry
    // to the back in place.
    send_item(rrtq_pkg::in_item_t'{rrtq_pkg::ACT_CREATE, 5'd31, 3'd7});
    send_item(rrtq_pkg::in_item_t'{rrtq_pkg::ACT_TICK, 5'd0, rrtq_pkg::TS_DEAD});
    // The held state is written again, and then a state code out of range is tried.
    send_item(rrtq_pkg::in_item_t'{rrtq_pkg::ACT_SET, 5'd2, rrtq_pkg::TS_READY});
    send_item(rrtq_pkg::in_item_t'{rrtq_pkg::ACT_SET, 5'd5, 3'd7});
    // An absent id, a task near the back, an idle task and a dead one.
    send_item(rrtq_pkg::in_item_t'{rrtq_pkg::ACT_SET, 5'd31, rrtq_pkg::TS_IDLE});
    send_item(rrtq_pkg::in_item_t'{rrtq_pkg::ACT_SET, 5'd16, rrtq_pkg::TS_BLOCKED});
    send_item(rrtq_pkg::in_item_t'{rrtq_pkg::ACT_SET, 5'd3, rrtq_pkg::TS_IDLE});
    send_item(rrtq_pkg::in_item_t'{rrtq_pkg::ACT_SET, 5'd2, rrtq_pkg::TS_DEAD});
    send_item(rrtq_pkg::in_item_t'{rrtq_pkg::ACT_TICK, 5'd0, rrtq_pkg::TS_DEAD});
    wait_drained();

    // Random part. The action mix changes every 120 items, so the ring fills and
    // empties in turn. Most targets are ids that are likely to be queued, so most sets
    // find their task.
    mode = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 120 == 0) begin
        mode       = $urandom_range(0, 3);
        send_burst = ($urandom_range(0, 3) == 0);
      end
      item.target_id = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(1, 17))
                                                    : 5'($urandom_range(0, 31));
      item.new_state = ($urandom_range(0, 99) < 88) ? 3'($urandom_range(0, 4))
                                                    : 3'($urandom_range(5, 7));
      pick = $urandom_range(0, 99);
      case (mode)
        0: item.action = (pick < 55) ? rrtq_pkg::ACT_CREATE :
                         (pick < 80) ? rrtq_pkg::ACT_TICK :
                         (pick < 97) ? rrtq_pkg::ACT_SET : ACT_UNUSED;
        1: item.action = (pick < 60) ? rrtq_pkg::ACT_TICK :
                         (pick < 80) ? rrtq_pkg::ACT_CREATE :
                         (pick < 97) ? rrtq_pkg::ACT_SET : ACT_UNUSED;
        2: item.action = (pick < 60) ? rrtq_pkg::ACT_SET :
                         (pick < 80) ? rrtq_pkg::ACT_TICK :
                         (pick < 97) ? rrtq_pkg::ACT_CREATE : ACT_UNUSED;
        default: begin
          // Tasks are killed and then swept out. This lowers the worker count, so new
          // creates reuse ids that are still queued.
          item.action = (pick < 45) ? rrtq_pkg::ACT_SET :
                        (pick < 85) ? rrtq_pkg::ACT_TICK :
                        (pick < 98) ? rrtq_pkg::ACT_CREATE : ACT_UNUSED;
          if (item.action == rrtq_pkg::ACT_SET && $urandom_range(0, 1) == 1)
            item.new_state = rrtq_pkg::TS_DEAD;
        end
      endcase
      send_item(item);
      if (i % 500 == 250) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/rrtq_pkg.sv
src/rrtq_ctrl.sv
src/rrtq_datapath.sv
src/round_robin_task_queue.sv
sim/rrtq_checker.sv
sim/tb_top.sv
